/* rtl/core/tae_pkg.sv */
// shared types, codes and decode helpers for the thumb alu execute core
`timescale 1ns / 1ps
`default_nettype none

package tae_pkg;

    // register file geometry
    localparam int unsigned REG_COUNT = 8;
    localparam int unsigned REG_AW    = 3;
    localparam int unsigned DATA_W    = 32;

    // item opcodes
    localparam logic [1:0] OP_EXEC = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // flag bit positions inside the nzcv word
    localparam int unsigned FLAG_N = 3;
    localparam int unsigned FLAG_Z = 2;
    localparam int unsigned FLAG_C = 1;
    localparam int unsigned FLAG_V = 0;

    // instruction formats
    localparam logic [2:0] FMT_NONE   = 3'd0;
    localparam logic [2:0] FMT_SHIFT  = 3'd1;
    localparam logic [2:0] FMT_ADDSUB = 3'd2;
    localparam logic [2:0] FMT_IMM    = 3'd3;
    localparam logic [2:0] FMT_ALU    = 3'd4;

    // shift kinds
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // 8-bit immediate operations
    localparam logic [1:0] IMM_MOV = 2'd0;
    localparam logic [1:0] IMM_CMP = 2'd1;
    localparam logic [1:0] IMM_ADD = 2'd2;
    localparam logic [1:0] IMM_SUB = 2'd3;

    // two-register alu operations
    localparam logic [3:0] ALU_AND = 4'd0;
    localparam logic [3:0] ALU_EOR = 4'd1;
    localparam logic [3:0] ALU_LSL = 4'd2;
    localparam logic [3:0] ALU_LSR = 4'd3;
    localparam logic [3:0] ALU_ASR = 4'd4;
    localparam logic [3:0] ALU_ADC = 4'd5;
    localparam logic [3:0] ALU_SBC = 4'd6;
    localparam logic [3:0] ALU_ROR = 4'd7;
    localparam logic [3:0] ALU_TST = 4'd8;
    localparam logic [3:0] ALU_NEG = 4'd9;
    localparam logic [3:0] ALU_CMP = 4'd10;
    localparam logic [3:0] ALU_CMN = 4'd11;
    localparam logic [3:0] ALU_ORR = 4'd12;
    localparam logic [3:0] ALU_MUL = 4'd13;
    localparam logic [3:0] ALU_BIC = 4'd14;
    localparam logic [3:0] ALU_MVN = 4'd15;

    // one input beat
    typedef struct packed {
        logic [1:0]        opcode;
        logic [15:0]       instruction;
        logic [REG_AW-1:0] reg_index;
        logic [DATA_W-1:0] write_value;
    } item_t;

    // one result beat, flags in nzcv order
    typedef struct packed {
        logic              reg_written;
        logic [REG_AW-1:0] dest_reg;
        logic [DATA_W-1:0] dest_value;
        logic [DATA_W-1:0] read_value;
        logic [3:0]        flags;
        logic              unsupported;
    } result_t;

    // register file write port
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [DATA_W-1:0] data;
    } wr_t;

    // classify an instruction word into one of the supported formats
    function automatic logic [2:0] decode_format(input logic [15:0] ins);
        logic [2:0] f;
        if (ins[15:11] == 5'b00011) begin
            f = FMT_ADDSUB;
        end else if (ins[15:13] == 3'b000) begin
            f = FMT_SHIFT;
        end else if (ins[15:13] == 3'b001) begin
            f = FMT_IMM;
        end else if (ins[15:10] == 6'b010000) begin
            f = FMT_ALU;
        end else begin
            f = FMT_NONE;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/tae_regfile.sv */
// low register file r0-r7 with registered reads and write forwarding
`timescale 1ns / 1ps
`default_nettype none

module tae_regfile (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        rd_en,
    input  wire logic [tae_pkg::REG_AW-1:0]  rd_addr_a,
    input  wire logic [tae_pkg::REG_AW-1:0]  rd_addr_b,
    input  wire tae_pkg::wr_t                wr,
    output logic      [tae_pkg::DATA_W-1:0]  rd_data_a,
    output logic      [tae_pkg::DATA_W-1:0]  rd_data_b
);
    import tae_pkg::*;

    logic [DATA_W-1:0]    mem_reg [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [DATA_W-1:0]    rd_a_reg;
    logic [DATA_W-1:0]    rd_b_reg;

    // entries read as zero until first written after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // storage array
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    // read both ports, taking a same-cycle write ahead of the array
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && (wr.addr == rd_addr_a))
            begin
                rd_a_reg <= wr.data;
            end
            else if (valid_reg[rd_addr_a])
            begin
                rd_a_reg <= mem_reg[rd_addr_a];
            end
            else
            begin
                rd_a_reg <= '0;
            end

            if (wr.en && (wr.addr == rd_addr_b))
            begin
                rd_b_reg <= wr.data;
            end
            else if (valid_reg[rd_addr_b])
            begin
                rd_b_reg <= mem_reg[rd_addr_b];
            end
            else
            begin
                rd_b_reg <= '0;
            end
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

/* rtl/core/tae_alu.sv */
// execute logic: adder, shifter, multiplier and flag update for one beat
`timescale 1ns / 1ps
`default_nettype none

module tae_alu (
    input  wire tae_pkg::item_t              item,
    input  wire logic [tae_pkg::DATA_W-1:0]  op_a,
    input  wire logic [tae_pkg::DATA_W-1:0]  op_b,
    input  wire logic [3:0]                  flags_in,
    output tae_pkg::result_t                 res
);
    import tae_pkg::*;

    logic [15:0]       ins;
    logic [2:0]        fmt;
    logic [3:0]        alu_op;
    logic [1:0]        imm_op;
    logic [DATA_W-1:0] imm8;

    // adder
    logic [DATA_W-1:0] add_x;
    logic [DATA_W-1:0] add_y;
    logic              add_sub;
    logic              add_cin;
    logic [DATA_W-1:0] add_y_eff;
    logic [DATA_W:0]   add_t;
    logic [DATA_W-1:0] add_r;
    logic              add_c;
    logic              add_v;

    // shifter
    logic [1:0]        sh_kind;
    logic [DATA_W-1:0] sh_v;
    logic [7:0]        sh_n;
    logic [4:0]        sh_m;
    logic              sh_big;
    logic              sh_is32;
    logic [DATA_W:0]   sh_tl;
    logic [DATA_W:0]   sh_tr;
    logic [DATA_W:0]   sh_ta;
    logic [2*DATA_W-1:0] sh_trot;
    logic [DATA_W-1:0] sh_r;
    logic              sh_c;

    // logical and multiply
    logic [DATA_W-1:0] mul_r;
    logic [DATA_W-1:0] log_r;

    // execute outcome
    logic              ex_write;
    logic [REG_AW-1:0] ex_dreg;
    logic [DATA_W-1:0] ex_val;
    logic [3:0]        ex_flags;

    assign ins    = item.instruction;
    assign fmt    = decode_format(ins);
    assign alu_op = ins[9:6];
    assign imm_op = ins[12:11];
    assign imm8   = {24'd0, ins[7:0]};

    // operand selection for the shared adder and shifter
    always_comb
    begin
        add_x   = op_a;
        add_y   = op_b;
        add_sub = 1'b0;
        add_cin = 1'b0;
        sh_kind = ins[12:11];
        sh_v    = op_a;
        sh_n    = {3'd0, ins[10:6]};
        // immediate lsr and asr by zero mean a shift by 32
        if ((ins[10:6] == 5'd0) && (ins[12:11] != SH_LSL))
        begin
            sh_n = 8'd32;
        end
        case (fmt)
            FMT_ADDSUB:
            begin
                add_y   = ins[10] ? {29'd0, ins[8:6]} : op_b;
                add_sub = ins[9];
                add_cin = ins[9];
            end
            FMT_IMM:
            begin
                add_y   = imm8;
                add_sub = (imm_op != IMM_ADD);
                add_cin = (imm_op != IMM_ADD);
            end
            FMT_ALU:
            begin
                sh_n = op_b[7:0];
                case (alu_op)
                    ALU_LSL: sh_kind = SH_LSL;
                    ALU_LSR: sh_kind = SH_LSR;
                    ALU_ASR: sh_kind = SH_ASR;
                    ALU_ROR: sh_kind = SH_ROR;
                    ALU_ADC: add_cin = flags_in[FLAG_C];
                    ALU_SBC:
                    begin
                        add_sub = 1'b1;
                        add_cin = flags_in[FLAG_C];
                    end
                    ALU_NEG:
                    begin
                        add_x   = '0;
                        add_sub = 1'b1;
                        add_cin = 1'b1;
                    end
                    ALU_CMP:
                    begin
                        add_sub = 1'b1;
                        add_cin = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // add with carry in; subtract is add of the inverted operand
    assign add_y_eff = add_sub ? ~add_y : add_y;
    assign add_t     = {1'b0, add_x} + {1'b0, add_y_eff} + {{DATA_W{1'b0}}, add_cin};
    assign add_r     = add_t[DATA_W-1:0];
    assign add_c     = add_t[DATA_W];
    assign add_v     = ~(add_x[DATA_W-1] ^ add_y_eff[DATA_W-1]) & (add_x[DATA_W-1] ^ add_r[DATA_W-1]);

    // barrel shifter with the extra carry bit carried along
    assign sh_m     = sh_n[4:0];
    assign sh_big   = |sh_n[7:5];
    assign sh_is32  = (sh_n[7:5] == 3'b001) && (sh_m == 5'd0);
    assign sh_tl    = {1'b0, sh_v} << sh_m;
    assign sh_tr    = {sh_v, 1'b0} >> sh_m;
    assign sh_ta    = $unsigned($signed({sh_v, 1'b0}) >>> sh_m);
    assign sh_trot  = {sh_v, sh_v} >> sh_m;

    always_comb
    begin
        sh_r = sh_v;
        sh_c = flags_in[FLAG_C];
        if (sh_n != 8'd0)
        begin
            case (sh_kind)
                SH_LSL:
                begin
                    if (!sh_big)
                    begin
                        sh_r = sh_tl[DATA_W-1:0];
                        sh_c = sh_tl[DATA_W];
                    end
                    else
                    begin
                        sh_r = '0;
                        sh_c = sh_is32 ? sh_v[0] : 1'b0;
                    end
                end
                SH_LSR:
                begin
                    if (!sh_big)
                    begin
                        sh_r = sh_tr[DATA_W:1];
                        sh_c = sh_tr[0];
                    end
                    else
                    begin
                        sh_r = '0;
                        sh_c = sh_is32 ? sh_v[DATA_W-1] : 1'b0;
                    end
                end
                SH_ASR:
                begin
                    if (!sh_big)
                    begin
                        sh_r = sh_ta[DATA_W:1];
                        sh_c = sh_ta[0];
                    end
                    else
                    begin
                        sh_r = {DATA_W{sh_v[DATA_W-1]}};
                        sh_c = sh_v[DATA_W-1];
                    end
                end
                default:
                begin
                    // rotate by a multiple of 32 keeps the value
                    if (sh_m == 5'd0)
                    begin
                        sh_r = sh_v;
                        sh_c = sh_v[DATA_W-1];
                    end
                    else
                    begin
                        sh_r = sh_trot[DATA_W-1:0];
                        sh_c = sh_trot[DATA_W-1];
                    end
                end
            endcase
        end
    end

    // multiply keeps the low word only
    assign mul_r = op_a * op_b;

    // logical results
    always_comb
    begin
        case (alu_op)
            ALU_EOR: log_r = op_a ^ op_b;
            ALU_ORR: log_r = op_a | op_b;
            ALU_MUL: log_r = mul_r;
            ALU_BIC: log_r = op_a & ~op_b;
            ALU_MVN: log_r = ~op_b;
            default: log_r = op_a & op_b;
        endcase
    end

    // instruction outcome and flag update
    always_comb
    begin
        ex_write = 1'b0;
        ex_dreg  = ins[2:0];
        ex_val   = '0;
        ex_flags = flags_in;
        case (fmt)
            FMT_ADDSUB:
            begin
                ex_write = 1'b1;
                ex_val   = add_r;
                ex_flags = {add_r[DATA_W-1], add_r == '0, add_c, add_v};
            end
            FMT_SHIFT:
            begin
                ex_write = 1'b1;
                ex_val   = sh_r;
                ex_flags = {sh_r[DATA_W-1], sh_r == '0, sh_c, flags_in[FLAG_V]};
            end
            FMT_IMM:
            begin
                ex_dreg = ins[10:8];
                case (imm_op)
                    IMM_MOV:
                    begin
                        ex_write         = 1'b1;
                        ex_val           = imm8;
                        ex_flags[FLAG_N] = 1'b0;
                        ex_flags[FLAG_Z] = (imm8 == '0);
                    end
                    IMM_CMP:
                    begin
                        ex_flags = {add_r[DATA_W-1], add_r == '0, add_c, add_v};
                    end
                    default:
                    begin
                        ex_write = 1'b1;
                        ex_val   = add_r;
                        ex_flags = {add_r[DATA_W-1], add_r == '0, add_c, add_v};
                    end
                endcase
            end
            FMT_ALU:
            begin
                case (alu_op)
                    ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR:
                    begin
                        ex_write = 1'b1;
                        ex_val   = sh_r;
                        ex_flags = {sh_r[DATA_W-1], sh_r == '0, sh_c, flags_in[FLAG_V]};
                    end
                    ALU_ADC, ALU_SBC, ALU_NEG:
                    begin
                        ex_write = 1'b1;
                        ex_val   = add_r;
                        ex_flags = {add_r[DATA_W-1], add_r == '0, add_c, add_v};
                    end
                    ALU_CMP, ALU_CMN:
                    begin
                        ex_flags = {add_r[DATA_W-1], add_r == '0, add_c, add_v};
                    end
                    ALU_TST:
                    begin
                        ex_flags[FLAG_N] = log_r[DATA_W-1];
                        ex_flags[FLAG_Z] = (log_r == '0);
                    end
                    default:
                    begin
                        ex_write         = 1'b1;
                        ex_val           = log_r;
                        ex_flags[FLAG_N] = log_r[DATA_W-1];
                        ex_flags[FLAG_Z] = (log_r == '0);
                    end
                endcase
            end
            default: ;
        endcase
    end

    // result beat per opcode
    always_comb
    begin
        res       = '0;
        res.flags = flags_in;
        case (item.opcode)
            OP_LOAD:
            begin
                res.reg_written = 1'b1;
                res.dest_reg    = item.reg_index;
                res.dest_value  = item.write_value;
            end
            OP_READ:
            begin
                res.read_value = op_a;
            end
            OP_EXEC:
            begin
                res.reg_written = ex_write;
                res.dest_reg    = ex_write ? ex_dreg : '0;
                res.dest_value  = ex_write ? ex_val : '0;
                res.flags       = ex_flags;
                res.unsupported = (fmt == FMT_NONE);
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/thumb_alu_execute_core.sv */
// top level of the thumb alu execute core: input stage, execute, result register
// each accepted item beat is held in the input stage, then in the result register
// throughput: one item per cycle when not stalled, set by one execute stage that
//   reads operands, updates r0-r7 and flags and loads the result register together
// operands are read from the register file as the item is accepted, with a
//   same-cycle register write forwarded into the read
// reset clears the pipeline valids and the flags; r0-r7 read as zero until written
`timescale 1ns / 1ps
`default_nettype none

module thumb_alu_execute_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire logic [1:0]                  opcode,
    input  wire logic [15:0]                 instruction,
    input  wire logic [tae_pkg::REG_AW-1:0]  reg_index,
    input  wire logic [tae_pkg::DATA_W-1:0]  write_value,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic                             reg_written,
    output logic      [tae_pkg::REG_AW-1:0]  dest_reg,
    output logic      [tae_pkg::DATA_W-1:0]  dest_value,
    output logic      [tae_pkg::DATA_W-1:0]  read_value,
    output logic                             flag_n,
    output logic                             flag_z,
    output logic                             flag_c,
    output logic                             flag_v,
    output logic                             unsupported
);
    import tae_pkg::*;

    logic              s1_valid_reg;
    item_t             s1_item_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    logic [3:0]        flags_reg;

    logic              accept;
    logic              advance;
    logic [2:0]        in_fmt;
    logic [REG_AW-1:0] addr_a;
    logic [REG_AW-1:0] addr_b;
    logic [DATA_W-1:0] op_a;
    logic [DATA_W-1:0] op_b;
    result_t           ex_res;
    wr_t               rf_wr;

    // handshake: execute when the result register is free or being emptied
    assign advance    = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    // operand addresses from the incoming beat
    assign in_fmt = decode_format(instruction);

    always_comb
    begin
        addr_a = instruction[5:3];
        addr_b = instruction[5:3];
        case (opcode)
            OP_READ: addr_a = reg_index;
            default:
            begin
                case (in_fmt)
                    FMT_ADDSUB: addr_b = instruction[8:6];
                    FMT_IMM:    addr_a = instruction[10:8];
                    FMT_ALU:    addr_a = instruction[2:0];
                    default: ;
                endcase
            end
        endcase
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.opcode      <= opcode;
            s1_item_reg.instruction <= instruction;
            s1_item_reg.reg_index   <= reg_index;
            s1_item_reg.write_value <= write_value;
        end
    end

    // register file write from the executing beat
    assign rf_wr.en   = advance && ex_res.reg_written;
    assign rf_wr.addr = ex_res.dest_reg;
    assign rf_wr.data = ex_res.dest_value;

    tae_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .wr        (rf_wr),
        .rd_data_a (op_a),
        .rd_data_b (op_b)
    );

    tae_alu u_alu (
        .item     (s1_item_reg),
        .op_a     (op_a),
        .op_b     (op_b),
        .flags_in (flags_reg),
        .res      (ex_res)
    );

    // condition flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (advance)
        begin
            flags_reg <= ex_res.flags;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= ex_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign reg_written  = out_res_reg.reg_written;
    assign dest_reg     = out_res_reg.dest_reg;
    assign dest_value   = out_res_reg.dest_value;
    assign read_value   = out_res_reg.read_value;
    assign flag_n       = out_res_reg.flags[FLAG_N];
    assign flag_z       = out_res_reg.flags[FLAG_Z];
    assign flag_c       = out_res_reg.flags[FLAG_C];
    assign flag_v       = out_res_reg.flags[FLAG_V];
    assign unsupported  = out_res_reg.unsupported;

    // load and read beats leave the flags alone
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (s1_item_reg.opcode != OP_EXEC)) |=> (flags_reg == $past(flags_reg)))
        else $error("flags changed on a non-execute beat");

    // an unsupported word never writes a register
    a_unsup_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && unsupported) |-> !reg_written)
        else $error("unsupported beat wrote a register");

    // destination fields are zero when nothing was written
    a_dest_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !reg_written) |-> ((dest_reg == '0) && (dest_value == '0)))
        else $error("destination fields set without a register write");

    // a read beat shows up as a result without a register write
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (s1_item_reg.opcode == OP_READ)) |=> (result_valid && !reg_written))
        else $error("read beat produced a write or no result");

endmodule

`default_nettype wire

/* test/thumb_alu_execute_core_test.sv */
// self-checking testbench for the thumb alu execute core, predicts every result beat
`timescale 1ns / 1ps

module thumb_alu_execute_core_test;

    import tae_pkg::*;

    // opcode value that the core must ignore apart from reporting the flags
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned RANDOM_ITEMS = 1400;

    // tracks r0-r7 and nzcv, queues the result beat each accepted item beat should produce
    class alu_scoreboard;
        bit [DATA_W-1:0] low_regs [REG_COUNT];
        bit [3:0]        nzcv;
        result_t         pending_q [$];
        int              errors;

        function void set_nz(bit [DATA_W-1:0] r);
            nzcv[FLAG_N] = r[31];
            nzcv[FLAG_Z] = (r == '0);
        endfunction

        // a + b + cin; subtraction passes ~b, which also gives the arm borrow and overflow
        function bit [DATA_W-1:0] add_carry(bit [DATA_W-1:0] a, bit [DATA_W-1:0] b, bit cin);
            bit [DATA_W:0] t;
            t = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, cin};
            set_nz(t[DATA_W-1:0]);
            nzcv[FLAG_C] = t[DATA_W];
            nzcv[FLAG_V] = ~(a[31] ^ b[31]) & (a[31] ^ t[31]);
            return t[DATA_W-1:0];
        endfunction

        // barrel shift with the carry rules for amounts 0, 32 and above 32
        function bit [DATA_W-1:0] shift_op(bit [1:0] kind, bit [DATA_W-1:0] v, int unsigned n);
            bit              c;
            bit [DATA_W-1:0] r;
            int unsigned     m;
            c = nzcv[FLAG_C];
            r = v;
            if (n != 0)
            begin
                case (kind)
                    SH_LSL:
                    begin
                        if (n < 32)
                        begin
                            c = v[32 - n];
                            r = v << n;
                        end
                        else
                        begin
                            c = (n == 32) ? v[0] : 1'b0;
                            r = '0;
                        end
                    end
                    SH_LSR:
                    begin
                        if (n < 32)
                        begin
                            c = v[n - 1];
                            r = v >> n;
                        end
                        else
                        begin
                            c = (n == 32) ? v[31] : 1'b0;
                            r = '0;
                        end
                    end
                    SH_ASR:
                    begin
                        if (n < 32)
                        begin
                            c = v[n - 1];
                            r = $signed(v) >>> n;
                        end
                        else
                        begin
                            c = v[31];
                            r = {DATA_W{v[31]}};
                        end
                    end
                    default:
                    begin
                        m = n % 32;
                        if (m == 0)
                        begin
                            c = v[31];
                        end
                        else
                        begin
                            r = (v >> m) | (v << (32 - m));
                            c = r[31];
                        end
                    end
                endcase
            end
            set_nz(r);
            nzcv[FLAG_C] = c;
            return r;
        endfunction

        // work out the result of one accepted item beat and update the shadow state
        function void note_item(item_t it);
            result_t         e;
            bit [15:0]       w;
            bit [2:0]        rd;
            bit [2:0]        rs;
            bit [DATA_W-1:0] a;
            bit [DATA_W-1:0] b;
            bit [DATA_W-1:0] res;
            bit              wr;
            int unsigned     n;
            e = '0;
            case (it.opcode)
                OP_LOAD:
                begin
                    low_regs[it.reg_index] = it.write_value;
                    e.reg_written = 1'b1;
                    e.dest_reg = it.reg_index;
                    e.dest_value = it.write_value;
                end
                OP_READ:
                begin
                    e.read_value = low_regs[it.reg_index];
                end
                OP_EXEC:
                begin
                    w = it.instruction;
                    rd = w[2:0];
                    rs = w[5:3];
                    wr = 1'b0;
                    res = '0;
                    if (w[15:11] == 5'b00011)
                    begin
                        // add/sub with register or 3-bit immediate
                        a = low_regs[rs];
                        b = w[10] ? {29'd0, w[8:6]} : low_regs[w[8:6]];
                        res = w[9] ? add_carry(a, ~b, 1'b1) : add_carry(a, b, 1'b0);
                        wr = 1'b1;
                    end
                    else if (w[15:13] == 3'b000)
                    begin
                        // shift by immediate, zero means 32 for lsr and asr
                        n = 32'(w[10:6]);
                        if (n == 0 && w[12:11] != SH_LSL)
                        begin
                            n = 32;
                        end
                        res = shift_op(w[12:11], low_regs[rs], n);
                        wr = 1'b1;
                    end
                    else if (w[15:13] == 3'b001)
                    begin
                        // mov/cmp/add/sub with 8-bit immediate
                        rd = w[10:8];
                        a = low_regs[rd];
                        b = {24'd0, w[7:0]};
                        wr = 1'b1;
                        case (w[12:11])
                            IMM_MOV:
                            begin
                                res = b;
                                set_nz(res);
                            end
                            IMM_CMP:
                            begin
                                void'(add_carry(a, ~b, 1'b1));
                                wr = 1'b0;
                            end
                            IMM_ADD: res = add_carry(a, b, 1'b0);
                            default: res = add_carry(a, ~b, 1'b1);
                        endcase
                    end
                    else if (w[15:10] == 6'b010000)
                    begin
                        // two-register alu ops, shifts use the low byte of rs
                        a = low_regs[rd];
                        b = low_regs[rs];
                        n = 32'(b[7:0]);
                        wr = 1'b1;
                        case (w[9:6])
                            ALU_AND:
                            begin
                                res = a & b;
                                set_nz(res);
                            end
                            ALU_EOR:
                            begin
                                res = a ^ b;
                                set_nz(res);
                            end
                            ALU_LSL: res = shift_op(SH_LSL, a, n);
                            ALU_LSR: res = shift_op(SH_LSR, a, n);
                            ALU_ASR: res = shift_op(SH_ASR, a, n);
                            ALU_ADC: res = add_carry(a, b, nzcv[FLAG_C]);
                            ALU_SBC: res = add_carry(a, ~b, nzcv[FLAG_C]);
                            ALU_ROR: res = shift_op(SH_ROR, a, n);
                            ALU_TST:
                            begin
                                set_nz(a & b);
                                wr = 1'b0;
                            end
                            ALU_NEG: res = add_carry('0, ~b, 1'b1);
                            ALU_CMP:
                            begin
                                void'(add_carry(a, ~b, 1'b1));
                                wr = 1'b0;
                            end
                            ALU_CMN:
                            begin
                                void'(add_carry(a, b, 1'b0));
                                wr = 1'b0;
                            end
                            ALU_ORR:
                            begin
                                res = a | b;
                                set_nz(res);
                            end
                            ALU_MUL:
                            begin
                                res = a * b;
                                set_nz(res);
                            end
                            ALU_BIC:
                            begin
                                res = a & ~b;
                                set_nz(res);
                            end
                            default:
                            begin
                                res = ~b;
                                set_nz(res);
                            end
                        endcase
                    end
                    else
                    begin
                        e.unsupported = 1'b1;
                    end
                    if (wr)
                    begin
                        low_regs[rd] = res;
                        e.reg_written = 1'b1;
                        e.dest_reg = rd;
                        e.dest_value = res;
                    end
                end
                default: ;
            endcase
            e.flags = nzcv;
            pending_q.push_back(e);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
            if (act_v !== exp_v)
            begin
                $display("%0t: %s mismatch, expected %h got %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // compare one accepted result beat against the oldest prediction
        function void check_result(result_t got);
            result_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: result beat with nothing outstanding, got %h", $time, got);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            compare_field("reg_written", DATA_W'(e.reg_written), DATA_W'(got.reg_written));
            compare_field("dest_reg", DATA_W'(e.dest_reg), DATA_W'(got.dest_reg));
            compare_field("dest_value", e.dest_value, got.dest_value);
            compare_field("read_value", e.read_value, got.read_value);
            compare_field("flag_n", DATA_W'(e.flags[FLAG_N]), DATA_W'(got.flags[FLAG_N]));
            compare_field("flag_z", DATA_W'(e.flags[FLAG_Z]), DATA_W'(got.flags[FLAG_Z]));
            compare_field("flag_c", DATA_W'(e.flags[FLAG_C]), DATA_W'(got.flags[FLAG_C]));
            compare_field("flag_v", DATA_W'(e.flags[FLAG_V]), DATA_W'(got.flags[FLAG_V]));
            compare_field("unsupported", DATA_W'(e.unsupported), DATA_W'(got.unsupported));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    logic [1:0]        opcode = OP_READ;
    logic [15:0]       instruction = '0;
    logic [REG_AW-1:0] reg_index = '0;
    logic [DATA_W-1:0] write_value = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic              reg_written;
    logic [REG_AW-1:0] dest_reg;
    logic [DATA_W-1:0] dest_value;
    logic [DATA_W-1:0] read_value;
    logic              flag_n;
    logic              flag_z;
    logic              flag_c;
    logic              flag_v;
    logic              unsupported;

    // no idling on either side while set
    bit steady = 1'b0;

    alu_scoreboard sb = new;

    thumb_alu_execute_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .instruction  (instruction),
        .reg_index    (reg_index),
        .write_value  (write_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .reg_written  (reg_written),
        .dest_reg     (dest_reg),
        .dest_value   (dest_value),
        .read_value   (read_value),
        .flag_n       (flag_n),
        .flag_z       (flag_z),
        .flag_c       (flag_c),
        .flag_v       (flag_v),
        .unsupported  (unsupported)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // instruction encoders
    function automatic logic [15:0] enc_shift(logic [1:0] kind, logic [4:0] amt,
                                              logic [2:0] rs, logic [2:0] rd);
        return {3'b000, kind, amt, rs, rd};
    endfunction

    function automatic logic [15:0] enc_addsub(logic imm, logic sub, logic [2:0] rn,
                                               logic [2:0] rs, logic [2:0] rd);
        return {5'b00011, imm, sub, rn, rs, rd};
    endfunction

    function automatic logic [15:0] enc_imm(logic [1:0] op, logic [2:0] rd, logic [7:0] imm);
        return {3'b001, op, rd, imm};
    endfunction

    function automatic logic [15:0] enc_alu(logic [3:0] op, logic [2:0] rs, logic [2:0] rd);
        return {6'b010000, op, rs, rd};
    endfunction

    function automatic item_t make_item(logic [1:0] op, logic [15:0] ins,
                                        logic [REG_AW-1:0] idx, logic [DATA_W-1:0] val);
        item_t it;
        it.opcode = op;
        it.instruction = ins;
        it.reg_index = idx;
        it.write_value = val;
        return it;
    endfunction

    // register values that hit the flag and shift corner cases
    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return ($urandom & 32'hFFFF_FF00) | $urandom_range(0, 40);
            5: return {24'($urandom), 3'($urandom), 5'd0};
            6: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] random_word();
        case ($urandom_range(0, 9))
            0, 1: return enc_shift(2'($urandom_range(0, 2)),
                                   ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom),
                                   3'($urandom), 3'($urandom));
            2: return enc_addsub(1'($urandom), 1'($urandom), 3'($urandom),
                                 3'($urandom), 3'($urandom));
            3: return enc_imm(2'($urandom), 3'($urandom), 8'($urandom));
            default: return enc_alu(4'($urandom), 3'($urandom), 3'($urandom));
        endcase
    endfunction

    // mostly well-formed instructions, with loads, reads and raw words mixed in
    function automatic item_t random_item();
        item_t it;
        int    sel;
        it = make_item(OP_EXEC, 16'($urandom), 3'($urandom), $urandom);
        sel = $urandom_range(0, 99);
        if (sel < 12)
        begin
            it.opcode = OP_LOAD;
            it.write_value = pick_operand();
        end
        else if (sel < 20)
        begin
            it.opcode = OP_READ;
        end
        else if (sel < 21)
        begin
            it.opcode = OP_UNUSED;
        end
        else if (sel >= 30)
        begin
            it.instruction = random_word();
        end
        return it;
    endfunction

    // present one item beat, hold it until accepted, then maybe idle
    task automatic drive_item(item_t it);
        int gap;
        item_valid <= 1'b1;
        opcode <= it.opcode;
        instruction <= it.instruction;
        reg_index <= it.reg_index;
        write_value <= it.write_value;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side back-pressure
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            n = steady ? 0 : pick_gap();
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // accepted beats on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                sb.note_item({opcode, instruction, reg_index, write_value});
            end
            if (result_valid && !result_stall)
            begin
                sb.check_result({reg_written, dest_reg, dest_value, read_value,
                                 flag_n, flag_z, flag_c, flag_v, unsupported});
            end
        end
    end

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("thumb_alu_execute_core_test: FAIL");
        $finish;
    end

    // stimulus
    initial
    begin
        item_t directed_q [$];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // operands: all ones, shift amount 0 in the low byte, sign bit, 32 and 33
        directed_q.push_back(make_item(OP_LOAD, '0, 3'd0, 32'hFFFF_FFFF));
        directed_q.push_back(make_item(OP_LOAD, '0, 3'd1, 32'h0000_0100));
        directed_q.push_back(make_item(OP_LOAD, '0, 3'd2, 32'h8000_0000));
        directed_q.push_back(make_item(OP_LOAD, '0, 3'd3, 32'h0000_0120));
        directed_q.push_back(make_item(OP_LOAD, '0, 3'd4, 32'h0000_0021));
        // immediate shift by zero: lsl keeps value and carry, lsr and asr shift by 32
        directed_q.push_back(make_item(OP_EXEC, enc_shift(SH_LSL, 5'd0, 3'd0, 3'd5), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_shift(SH_LSR, 5'd0, 3'd2, 3'd5), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_shift(SH_ASR, 5'd0, 3'd2, 3'd6), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_addsub(1'b0, 1'b0, 3'd1, 3'd0, 3'd5), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_addsub(1'b1, 1'b1, 3'd7, 3'd1, 3'd6), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_imm(IMM_MOV, 3'd5, 8'hFF), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_imm(IMM_CMP, 3'd2, 8'h00), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_imm(IMM_ADD, 3'd6, 8'hFF), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_imm(IMM_SUB, 3'd7, 8'h01), '0, '0));
        // register shifts by 32, by 0, ror by a multiple of 32, asr above 32
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_LSL, 3'd3, 3'd5), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_LSR, 3'd1, 3'd0), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_ROR, 3'd3, 3'd0), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_ASR, 3'd4, 3'd2), '0, '0));
        // remaining alu ops, compares and tests leave registers alone
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_ADC, 3'd0, 3'd5), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_SBC, 3'd1, 3'd6), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_TST, 3'd2, 3'd0), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_NEG, 3'd4, 3'd5), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_CMP, 3'd1, 3'd0), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_CMN, 3'd1, 3'd0), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_ORR, 3'd4, 3'd3), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_MUL, 3'd0, 3'd4), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_BIC, 3'd1, 3'd3), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_MVN, 3'd0, 3'd6), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_AND, 3'd0, 3'd2), '0, '0));
        directed_q.push_back(make_item(OP_EXEC, enc_alu(ALU_EOR, 3'd2, 3'd7), '0, '0));
        // outside formats 1-4, unused opcode, read back
        directed_q.push_back(make_item(OP_EXEC, 16'hFFFF, '0, '0));
        directed_q.push_back(make_item(OP_UNUSED, 16'hFFFF, 3'd7, 32'hFFFF_FFFF));
        directed_q.push_back(make_item(OP_READ, '0, 3'd5, '0));

        foreach (directed_q[i])
        begin
            drive_item(directed_q[i]);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady = (i >= 500 && i < 700);
            drive_item(random_item());
        end
        item_valid <= 1'b0;
        steady = 1'b0;

        // drain, then give the pipeline time to show any stray beat
        while (sb.pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("thumb_alu_execute_core_test: PASS");
        end
        else
        begin
            $display("thumb_alu_execute_core_test: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/tae_pkg.sv
rtl/core/tae_regfile.sv
rtl/core/tae_alu.sv
rtl/core/thumb_alu_execute_core.sv
test/thumb_alu_execute_core_test.sv
